### hw/rtl/hcbp_pkg.sv
// Shared constants for the code-table bit packer.
`default_nettype none
package hcbp_pkg;

  localparam int SYMBOL_COUNT_DEF  = 29;
  localparam int MAX_CODE_BITS_DEF = 32;

  // Request field widths
  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int ESYM_W   = 5;
  localparam int ELEN_W   = 6;
  localparam int CODE_W   = 32;
  localparam int IN_DATA_W = 56;   // 51 field bits padded to whole bytes

  localparam int IN_BYTE_LO = 0;
  localparam int ESYM_LO    = IN_BYTE_LO + BYTE_W;
  localparam int ELEN_LO    = ESYM_LO + ESYM_W;
  localparam int CODE_LO    = ELEN_LO + ELEN_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam logic [BYTE_W-1:0] CHAR_A       = 8'd97;
  localparam logic [BYTE_W-1:0] CHAR_Z       = 8'd122;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;

  localparam logic [ESYM_W-1:0] SYM_SPACE   = 5'd26;
  localparam logic [ESYM_W-1:0] SYM_NEWLINE = 5'd27;
  localparam logic [ESYM_W-1:0] SYM_END     = 5'd28;

endpackage
`default_nettype wire

### hw/rtl/huffman_code_table_bit_packer.sv
// Table-driven prefix-code encoder that packs code bits serially into bytes.
// A table write takes effect on acceptance; an encode or finish request reads the
//   table, loads the code and shifts its bits out serially; a finish then flushes
//   any partial byte. A new request is taken only in idle, once the previous one is
//   through; a full output register stalls the bit-serial shifter.
// Reset clears the control state and the partial byte; the code table is undefined
//   until written.
`default_nettype none
module huffman_code_table_bit_packer #(
  parameter int SYMBOL_COUNT  = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_BITS = hcbp_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // in_byte[7:0], entry_symbol[12:8], entry_length[18:13], entry_code[50:19], zero pad
  input  wire logic [hcbp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // kind[1:0]
  input  wire logic [hcbp_pkg::KIND_W-1:0]    s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // out_byte[7:0]
  output logic [hcbp_pkg::BYTE_W-1:0]         m_axis_tdata,
  // last_of_run
  output logic                                m_axis_tlast,
  // stream_end[0]
  output logic [0:0]                          m_axis_tuser
);
  import hcbp_pkg::*;

  localparam int SW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LW = $clog2(MAX_CODE_BITS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_SHIFT} state_t;

  state_t            state;
  logic [LW-1:0]     len_mem [SYMBOL_COUNT];
  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LW-1:0]     rd_len;
  logic [CODE_W-1:0] rd_code;
  logic              sym_ok;
  logic              finish;
  logic [LW-1:0]     rem;
  logic [CODE_W-1:0] code_sr;
  logic [BYTE_W-1:0] acc;
  logic [2:0]        cnt;

  kind_t             kind;
  logic [BYTE_W-1:0] in_byte;
  logic [ESYM_W-1:0] entry_symbol;
  logic [ELEN_W-1:0] entry_length;
  logic [CODE_W-1:0] entry_code;
  logic [ESYM_W-1:0] map_sym;
  logic [ESYM_W-1:0] rd_sym;
  logic              accept;
  logic              wr_en;
  logic [LW-1:0]     len_sat;
  logic              ofree;
  logic [LW-1:0]     rem_after;
  logic              bit_in;
  logic [BYTE_W-1:0] byte_done;
  logic [BYTE_W-1:0] pad_byte;
  logic              run_last;
  logic              out_load;

  assign kind         = kind_t'(s_axis_tuser);
  assign in_byte      = s_axis_tdata[IN_BYTE_LO +: BYTE_W];
  assign entry_symbol = s_axis_tdata[ESYM_LO +: ESYM_W];
  assign entry_length = s_axis_tdata[ELEN_LO +: ELEN_W];
  assign entry_code   = s_axis_tdata[CODE_LO +: CODE_W];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_en = accept && (kind == KIND_WRITE) && (int'(entry_symbol) < SYMBOL_COUNT);

  always_comb begin
    if (in_byte >= CHAR_A && in_byte <= CHAR_Z) begin
      map_sym = ESYM_W'(in_byte - CHAR_A);
    end else if (in_byte == CHAR_SPACE) begin
      map_sym = SYM_SPACE;
    end else if (in_byte == CHAR_NEWLINE) begin
      map_sym = SYM_NEWLINE;
    end else begin
      map_sym = SYM_END;
    end
  end

  assign rd_sym  = (kind == KIND_FINISH) ? SYM_END : map_sym;
  assign len_sat = (int'(entry_length) > MAX_CODE_BITS) ? LW'(MAX_CODE_BITS)
                                                        : LW'(entry_length);

  // Code table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      len_mem[SW'(entry_symbol)]  <= len_sat;
      code_mem[SW'(entry_symbol)] <= entry_code;
    end
    rd_len  <= len_mem[SW'(rd_sym)];
    rd_code <= code_mem[SW'(rd_sym)];
  end

  assign ofree     = !m_axis_tvalid || m_axis_tready;
  assign rem_after = rem - LW'(1);
  assign bit_in    = code_sr[CODE_W-1];
  assign byte_done = {acc[BYTE_W-2:0], bit_in};
  assign pad_byte  = acc << (3'd0 - cnt);
  assign run_last  = (rem_after < LW'(8)) && !(finish && rem_after != '0);
  assign out_load  = (state == ST_SHIFT) && ofree &&
                     (((rem != '0) && (cnt == 3'd7)) ||
                      ((rem == '0) && finish && (cnt != 3'd0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sym_ok        <= 1'b0;
      finish        <= 1'b0;
      rem           <= '0;
      code_sr       <= '0;
      acc           <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tlast  <= 1'b0;
      m_axis_tuser  <= '0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (kind == KIND_ENCODE || kind == KIND_FINISH)) begin
            sym_ok <= (int'(rd_sym) < SYMBOL_COUNT);
            finish <= (kind == KIND_FINISH);
            state  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          rem     <= sym_ok ? rd_len : '0;
          code_sr <= rd_code;
          state   <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (rem != '0) begin
            if (cnt != 3'd7 || ofree) begin
              acc     <= byte_done;
              cnt     <= cnt + 3'd1;
              code_sr <= code_sr << 1;
              rem     <= rem_after;
              if (cnt == 3'd7) begin
                m_axis_tdata  <= byte_done;
                m_axis_tlast  <= run_last;
                m_axis_tuser  <= run_last && finish;
              end
            end
          end else if (finish && cnt != 3'd0) begin
            if (ofree) begin
              m_axis_tdata  <= pad_byte;
              m_axis_tlast  <= 1'b1;
              m_axis_tuser  <= 1'b1;
              acc           <= '0;
              cnt           <= '0;
              state         <= ST_IDLE;
            end
          end else begin
            if (finish) begin
              acc <= '0;
              cnt <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
